### rtl/ftc_pkg.sv
// Shared types, character codes and keyword tables for the field type classifier.
// No dependencies; used by ftc_lexer and field_type_classifier.
`default_nettype none

package ftc_pkg;

    typedef enum logic [2:0] {
        TYPE_EMPTY  = 3'd0,
        TYPE_UINT   = 3'd1,
        TYPE_SINT   = 3'd2,
        TYPE_FLOAT  = 3'd3,
        TYPE_BOOL   = 3'd4,
        TYPE_STRING = 3'd5
    } field_type_t;

    typedef struct packed {
        logic       step;
        logic       eof;
        logic [7:0] ch;
    } lex_step_t;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_E_LOWER = 8'h65;
    localparam logic [7:0] CH_E_UPPER = 8'h45;

    localparam logic [2:0] TRUE_LEN   = 3'd4;
    localparam logic [2:0] FALSE_LEN  = 3'd5;
    localparam logic [2:0] COUNT_MAX  = 3'd7;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return (c == CH_E_LOWER) || (c == CH_E_UPPER);
    endfunction

    function automatic logic [7:0] true_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h54;
            2'd1:    c = 8'h72;
            2'd2:    c = 8'h75;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] false_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h46;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/field_type_classifier.sv
// Field type classifier top level: input register, lexer, result register.
// Depends on ftc_pkg and ftc_lexer.
//
// Usage:
//   The s_ channel carries one item per character of a text field
//   (s_ch, s_end_of_field = 0), closed by one terminator item
//   (s_end_of_field = 1). The m_ channel carries one item per field,
//   m_field_type: 0 empty, 1 unsigned int, 2 signed int, 3 float,
//   4 bool, 5 string.
//   Throughput: one item per cycle while no result is held by a low
//   m_ready, set by the single lexer step between the input register and
//   the result register. A terminator passes from the input register
//   into the result register, which drives m_valid. Character items never
//   wait for the m_ channel. While a result is held by a low m_ready, a
//   terminator in the input register waits there and holds s_ready low.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   lexer to its empty-field state.
`default_nettype none

module field_type_classifier (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_end_of_field,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_field_type
);

    logic                 in_valid_reg;
    logic [7:0]           ch_reg;
    logic                 eof_reg;
    logic                 out_valid_reg;
    ftc_pkg::field_type_t type_reg;

    logic                 out_free;
    logic                 advance;
    ftc_pkg::lex_step_t   step;
    ftc_pkg::field_type_t lex_type;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!eof_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    assign step.step = advance;
    assign step.eof  = eof_reg;
    assign step.ch   = ch_reg;

    ftc_lexer u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_in    (step),
        .field_type (lex_type)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            ch_reg  <= s_ch;
            eof_reg <= s_end_of_field;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && eof_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && eof_reg) begin
            type_reg <= lex_type;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_field_type = type_reg;

    a_term_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && eof_reg |=> m_valid)
        else $error("terminator step did not load a result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && eof_reg && m_valid && !m_ready)
        else $error("input stalled without a blocked terminator");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("registers not empty after reset");

    a_type_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_field_type <= ftc_pkg::TYPE_STRING)
        else $error("result type code out of range");

endmodule

`default_nettype wire

### rtl/ftc_lexer.sv
// Number-syntax state machine and keyword match for one field.
// Depends on ftc_pkg; instantiated by field_type_classifier.
`default_nettype none

module ftc_lexer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ftc_pkg::lex_step_t step_in,
    output ftc_pkg::field_type_t    field_type
);

    typedef enum logic [3:0] {
        LEX_START   = 4'd0,
        LEX_SIGN    = 4'd1,
        LEX_INT     = 4'd2,
        LEX_POINT   = 4'd3,
        LEX_FRAC    = 4'd4,
        LEX_EXPE    = 4'd5,
        LEX_EXPSIGN = 4'd6,
        LEX_EXP     = 4'd7,
        LEX_STRING  = 4'd8
    } lex_state_t;

    lex_state_t state_reg, state_next;
    logic       seen_sign_reg, seen_sign_next;
    logic       seen_digit_reg, seen_digit_next;
    logic [2:0] count_reg, count_next;
    logic       true_reg, true_next;
    logic       false_reg, false_next;

    logic [7:0] c;
    logic       c_digit;
    logic       c_sign;
    logic       c_exp;
    logic       c_point;

    assign c       = step_in.ch;
    assign c_digit = ftc_pkg::is_digit(c);
    assign c_sign  = ftc_pkg::is_sign(c);
    assign c_exp   = ftc_pkg::is_exp(c);
    assign c_point = (c == ftc_pkg::CH_POINT);

    always_comb begin
        state_next      = LEX_STRING;
        seen_sign_next  = seen_sign_reg;
        seen_digit_next = seen_digit_reg;
        unique case (state_reg)
            LEX_START: begin
                if (c_sign) begin
                    seen_sign_next = 1'b1;
                    state_next     = LEX_SIGN;
                end else if (c_digit) begin
                    seen_digit_next = 1'b1;
                    state_next      = LEX_INT;
                end else if (c_point) begin
                    state_next = LEX_POINT;
                end
            end
            LEX_SIGN: begin
                if (c_digit) begin
                    seen_digit_next = 1'b1;
                    state_next      = LEX_INT;
                end else if (c_point) begin
                    state_next = LEX_POINT;
                end
            end
            LEX_INT: begin
                if (c_digit) begin
                    seen_digit_next = 1'b1;
                    state_next      = LEX_INT;
                end else if (c_point) begin
                    state_next = LEX_POINT;
                end else if (c_exp) begin
                    state_next = LEX_EXPE;
                end
            end
            LEX_POINT, LEX_FRAC: begin
                if (c_digit) begin
                    seen_digit_next = 1'b1;
                    state_next      = LEX_FRAC;
                end else if (c_exp) begin
                    state_next = LEX_EXPE;
                end
            end
            LEX_EXPE: begin
                if (c_sign) begin
                    state_next = LEX_EXPSIGN;
                end else if (c_digit) begin
                    state_next = LEX_EXP;
                end
            end
            LEX_EXPSIGN, LEX_EXP: begin
                if (c_digit) begin
                    state_next = LEX_EXP;
                end
            end
            default: begin
                state_next = LEX_STRING;
            end
        endcase
    end

    always_comb begin
        if (count_reg < ftc_pkg::TRUE_LEN) begin
            true_next = true_reg && (c == ftc_pkg::true_char(count_reg[1:0]));
        end else begin
            true_next = 1'b0;
        end
        if (count_reg < ftc_pkg::FALSE_LEN) begin
            false_next = false_reg && (c == ftc_pkg::false_char(count_reg));
        end else begin
            false_next = 1'b0;
        end
        if (count_reg < ftc_pkg::COUNT_MAX) begin
            count_next = count_reg + 3'd1;
        end else begin
            count_next = count_reg;
        end
    end

    always_comb begin
        unique case (state_reg)
            LEX_START: begin
                field_type = ftc_pkg::TYPE_EMPTY;
            end
            LEX_INT: begin
                field_type = seen_sign_reg ? ftc_pkg::TYPE_SINT : ftc_pkg::TYPE_UINT;
            end
            LEX_FRAC: begin
                field_type = ftc_pkg::TYPE_FLOAT;
            end
            LEX_POINT, LEX_EXPE, LEX_EXPSIGN, LEX_EXP: begin
                field_type = seen_digit_reg ? ftc_pkg::TYPE_FLOAT : ftc_pkg::TYPE_STRING;
            end
            LEX_STRING: begin
                if ((true_reg && count_reg == ftc_pkg::TRUE_LEN)
                        || (false_reg && count_reg == ftc_pkg::FALSE_LEN)) begin
                    field_type = ftc_pkg::TYPE_BOOL;
                end else begin
                    field_type = ftc_pkg::TYPE_STRING;
                end
            end
            default: begin
                field_type = ftc_pkg::TYPE_STRING;
            end
        endcase
    end

    // Close the field on reset or a terminator, otherwise advance on the character.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_in.step && step_in.eof)) begin
            state_reg      <= LEX_START;
            seen_sign_reg  <= 1'b0;
            seen_digit_reg <= 1'b0;
            count_reg      <= 3'd0;
            true_reg       <= 1'b1;
            false_reg      <= 1'b1;
        end else if (step_in.step) begin
            state_reg      <= state_next;
            seen_sign_reg  <= seen_sign_next;
            seen_digit_reg <= seen_digit_next;
            count_reg      <= count_next;
            true_reg       <= true_next;
            false_reg      <= false_next;
        end
    end

endmodule

`default_nettype wire
